/* rtl/windowed_peak_picker_assert.svh */
// Assertion macros used by the peak picker RTL.
`ifndef WINDOWED_PEAK_PICKER_ASSERT_SVH
`define WINDOWED_PEAK_PICKER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define WPP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define WPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wpp_pkg.sv */
// Shared types and constants of the windowed peak picker.
package wpp_pkg;

    localparam int unsigned CNT_W = 17;
    localparam int unsigned IDX_W = 16;

    localparam logic [CNT_W-1:0] POS_MAX    = '1;
    localparam logic [CNT_W-1:0] WINDOW_RST = 17'd64;
    localparam logic [CNT_W-1:0] RECORD_RST = 17'd65536;

    typedef enum logic [1:0] {
        REG_WINDOW   = 2'd0,
        REG_RECORD   = 2'd1,
        REG_FIND_MIN = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] window_length;
        logic [CNT_W-1:0] record_length;
        logic             find_minimum;
    } t_cfg;

    typedef struct packed {
        logic             finished;
        logic [CNT_W-1:0] fill;
        logic             emit;
    } t_status;

endpackage

/* rtl/windowed_peak_picker.sv */
// Windowed peak picker: one maximum or minimum per window of a sample record.
//
// Samples of a record stream in on the slave side, one per transfer; a tuser
// bit marks the first sample of a record and restarts the search. Each window
// of window_length samples is searched for its maximum (find_minimum = 0) or
// minimum (find_minimum = 1), the earliest extreme winning a tie, and at the
// window's last sample one result transfer carries the peak's index and value.
// The next window opens window_length samples after that peak; a window opens
// only while its start lies below record_length - 2 * window_length, after
// which nothing is emitted until the next record start. Nothing is emitted
// before the first record start after reset. A window length of zero acts as
// one and a record length above MAX_RECORD is clipped to it. Throughput is one
// sample per clock unless the input stalls: the compare and counter update for
// a sample sit between the state registers and the result register, so a result
// is valid in the cycle after the sample that closes its window. The input
// stalls only while that result register is full and the master side does not
// take it. Write the configuration registers (byte addresses 0, 4, 8) only while
// no result is outstanding; new values take effect on the next sample.
module windowed_peak_picker #(
    parameter int MAX_RECORD  = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // sample stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // sample
    input  logic [0:0]             s_axis_tuser,               // record_start
    // peak stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [((wpp_pkg::IDX_W+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata // peak_index, peak_value
);

    localparam int unsigned OUT_W = ((wpp_pkg::IDX_W + SAMPLE_BITS + 7) / 8) * 8;

    wpp_pkg::t_cfg                  w_cfg;
    wpp_pkg::t_status               w_stat;
    logic                           w_accept;
    logic [wpp_pkg::IDX_W-1:0]      w_peak_index;
    logic signed [SAMPLE_BITS-1:0]  w_peak_value;

    logic                           r_out_valid;
    logic [wpp_pkg::IDX_W-1:0]      r_peak_index;
    logic signed [SAMPLE_BITS-1:0]  r_peak_value;

    wpp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Take a new sample whenever the result register is free or being emptied.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    wpp_search #(
        .MAX_RECORD  (MAX_RECORD),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_accept       (w_accept),
        .i_sample       (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_record_start (s_axis_tuser[0]),
        .o_peak_index   (w_peak_index),
        .o_peak_value   (w_peak_value),
        .o_status       (w_stat)
    );

    // Result register: load on a closing window, drop once the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the payload until the next window closes.
    always_ff @(posedge i_clk) begin
        if (w_stat.emit) begin
            r_peak_index <= w_peak_index;
            r_peak_value <= w_peak_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_peak_value, r_peak_index});

`include "windowed_peak_picker_assert.svh"

    // A fresh result only ever follows an accepted sample.
    `WPP_ASSERT_IMPL(a_result_follows_sample, i_clk, i_rst_n, $rose(r_out_valid), $past(w_accept), "result appeared without an accepted sample")

    // A finished search stays silent until a record start arrives.
    `WPP_ASSERT_NEXT(a_finished_silent, i_clk, i_rst_n, w_stat.finished && !(w_accept && s_axis_tuser[0]), !$rose(r_out_valid), "result emitted after the search had finished")

    // Closing a window empties the fill count.
    `WPP_ASSERT_NEXT(a_fill_cleared, i_clk, i_rst_n, w_stat.emit, w_stat.fill == '0, "window fill not cleared after a result")

endmodule

/* rtl/wpp_apb_regs.sv */
// APB register file holding the peak picker configuration.
module wpp_apb_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output wpp_pkg::t_cfg       o_cfg
);

    wpp_pkg::t_cfg     r_cfg;
    wpp_pkg::t_reg_idx w_idx;
    logic              w_write;

    assign pready  = 1'b1;
    assign w_idx   = wpp_pkg::t_reg_idx'(paddr[3:2]);
    assign w_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length <= wpp_pkg::WINDOW_RST;
            r_cfg.record_length <= wpp_pkg::RECORD_RST;
            r_cfg.find_minimum  <= 1'b0;
        end else if (w_write) begin
            unique case (w_idx)
                wpp_pkg::REG_WINDOW:   r_cfg.window_length <= pwdata[wpp_pkg::CNT_W-1:0];
                wpp_pkg::REG_RECORD:   r_cfg.record_length <= pwdata[wpp_pkg::CNT_W-1:0];
                wpp_pkg::REG_FIND_MIN: r_cfg.find_minimum  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            wpp_pkg::REG_WINDOW:   prdata = 32'(r_cfg.window_length);
            wpp_pkg::REG_RECORD:   prdata = 32'(r_cfg.record_length);
            wpp_pkg::REG_FIND_MIN: prdata = 32'(r_cfg.find_minimum);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/wpp_search.sv */
// Window search state and the per-sample compare and counter update.
module wpp_search #(
    parameter int MAX_RECORD  = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wpp_pkg::t_cfg                 i_cfg,
    input  logic                          i_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_record_start,
    output logic [wpp_pkg::IDX_W-1:0]     o_peak_index,
    output logic signed [SAMPLE_BITS-1:0] o_peak_value,
    output wpp_pkg::t_status              o_status
);

    localparam int unsigned CW = wpp_pkg::CNT_W;
    localparam int unsigned IW = wpp_pkg::IDX_W;
    localparam logic [24:0] MAX_REC = 25'(MAX_RECORD);

    logic [CW-1:0]          r_pos, n_pos;
    logic [CW-1:0]          r_begin, n_begin;
    logic [CW-1:0]          r_fill, n_fill;
    logic [CW-1:0]          r_skip, n_skip;
    logic                   r_fin, n_fin;
    logic signed [SAMPLE_BITS-1:0] r_best, n_best;
    logic [IW-1:0]          r_bpos, n_bpos;

    logic [CW-1:0]          w_win;
    logic [CW-1:0]          w_rec;
    logic [CW-1:0]          w_pos0;
    logic [CW+1:0]          w_reach;
    logic                   w_better;
    logic                   w_emit;
    logic [CW:0]            w_next;
    logic [CW:0]            w_after;

    assign w_win = (i_cfg.window_length == '0) ? CW'(1) : i_cfg.window_length;
    assign w_rec = ({8'd0, i_cfg.record_length} > MAX_REC) ? MAX_REC[CW-1:0]
                                                           : i_cfg.record_length;

    always_comb begin
        // start from the record-start view of the state
        n_pos   = i_record_start ? '0 : r_pos;
        n_begin = i_record_start ? '0 : r_begin;
        n_fill  = i_record_start ? '0 : r_fill;
        n_skip  = i_record_start ? '0 : r_skip;
        n_fin   = i_record_start ? 1'b0 : r_fin;
        n_best  = r_best;
        n_bpos  = r_bpos;
        w_pos0  = n_pos;
        w_reach = (CW+2)'(n_begin) + {1'b0, w_win, 1'b0};
        w_better = i_cfg.find_minimum ? (i_sample < r_best) : (i_sample > r_best);
        w_emit  = 1'b0;
        w_next  = '0;
        w_after = '0;

        if (!n_fin) begin
            if (n_skip != '0) begin
                n_skip = n_skip - CW'(1);
            end else if (n_fill == '0) begin
                if (w_reach < (CW+2)'(w_rec)) begin
                    n_best = i_sample;
                    n_bpos = w_pos0[IW-1:0];
                    n_fill = CW'(1);
                end else begin
                    n_fin = 1'b1;
                end
            end else begin
                if (w_better) begin
                    n_best = i_sample;
                    n_bpos = w_pos0[IW-1:0];
                end
                n_fill = n_fill + CW'(1);
            end

            if (!n_fin && n_fill != '0 && n_fill >= w_win) begin
                w_emit  = 1'b1;
                w_next  = (CW+1)'(n_bpos) + (CW+1)'(w_win);
                w_after = (CW+1)'(w_pos0) + (CW+1)'(1);
                n_begin = w_next[CW-1:0];
                n_skip  = (w_next > w_after) ? CW'(w_next - w_after) : '0;
                n_fill  = '0;
            end
        end

        // saturate the position counter at its top
        if (w_pos0 != wpp_pkg::POS_MAX) begin
            n_pos = w_pos0 + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_begin <= '0;
            r_fill  <= '0;
            r_skip  <= '0;
            r_fin   <= 1'b1;
            r_best  <= '0;
            r_bpos  <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_fill  <= n_fill;
            r_skip  <= n_skip;
            r_fin   <= n_fin;
            r_best  <= n_best;
            r_bpos  <= n_bpos;
        end
    end

    assign o_peak_index     = n_bpos;
    assign o_peak_value     = n_best;
    assign o_status.finished = r_fin;
    assign o_status.fill     = r_fill;
    assign o_status.emit     = i_accept && w_emit;

endmodule

/* dv/tb_windowed_peak_picker.sv */
// Self-checking testbench for the windowed peak picker: streams sample records, predicts the peaks.
module tb_windowed_peak_picker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CW           = wpp_pkg::CNT_W;
    localparam int unsigned MAX_REC      = 65536;
    localparam int unsigned RAND_PHASES  = 13;
    localparam int unsigned PHASE_ITEMS  = 48;
    localparam int unsigned SETTLE_CYCLES = 8;      // result lands in the cycle after its sample
    localparam int unsigned STALL_LIMIT  = 2000;    // cycles without any transfer

    typedef struct {
        logic [15:0]        index;
        logic signed [15:0] value;
    } t_peak;

    // Tracks the peak search, holds the peaks still owed by the block and checks them.
    class peak_scoreboard;
        logic [CW-1:0]      win_len;
        logic [CW-1:0]      rec_len;
        logic               min_mode;
        logic [CW-1:0]      pos;
        logic [CW-1:0]      win_begin;
        logic [CW-1:0]      fill;
        logic [CW-1:0]      skip;
        logic signed [15:0] best_val;
        logic [15:0]        best_pos;
        logic               finished;
        t_peak              owed_peaks[$];
        int unsigned        errors;

        function new();
            win_len   = wpp_pkg::WINDOW_RST;
            rec_len   = wpp_pkg::RECORD_RST;
            min_mode  = 1'b0;
            pos       = '0;
            win_begin = '0;
            fill      = '0;
            skip      = '0;
            best_val  = '0;
            best_pos  = '0;
            finished  = 1'b1;
            errors    = 0;
        endfunction

        function void set_reg(wpp_pkg::t_reg_idx idx, logic [31:0] val);
            case (idx)
                wpp_pkg::REG_WINDOW:   win_len  = val[CW-1:0];
                wpp_pkg::REG_RECORD:   rec_len  = val[CW-1:0];
                wpp_pkg::REG_FIND_MIN: min_mode = val[0];
                default: ;
            endcase
        endfunction

        // Advance the search by one accepted sample; queue a peak if a window closes.
        function void note_sample(logic signed [15:0] smp, logic rec_start);
            longint unsigned w;
            longint unsigned rec;
            longint unsigned nxt;
            longint unsigned after;
            t_peak           pk;
            w   = (win_len == '0) ? 1 : longint'(win_len);
            rec = (rec_len > MAX_REC) ? MAX_REC : longint'(rec_len);
            if (rec_start) begin
                pos       = '0;
                win_begin = '0;
                fill      = '0;
                skip      = '0;
                finished  = 1'b0;
            end
            if (!finished) begin
                if (skip != '0) begin
                    skip = skip - CW'(1);
                end else if (fill == '0) begin
                    // open a window only while its start stays clear of the record tail
                    if (longint'(win_begin) + 2 * w < rec) begin
                        best_val = smp;
                        best_pos = pos[15:0];
                        fill     = CW'(1);
                    end else begin
                        finished = 1'b1;
                    end
                end else begin
                    // strict compare: the earliest extreme keeps a tie
                    if (min_mode ? (smp < best_val) : (smp > best_val)) begin
                        best_val = smp;
                        best_pos = pos[15:0];
                    end
                    fill = fill + CW'(1);
                end
                if (!finished && fill != '0 && longint'(fill) >= w) begin
                    nxt       = longint'(best_pos) + w;
                    after     = longint'(pos) + 1;
                    pk.index  = best_pos;
                    pk.value  = best_val;
                    owed_peaks = {owed_peaks, pk};
                    win_begin = nxt[CW-1:0];
                    skip      = (nxt > after) ? CW'(nxt - after) : '0;
                    fill      = '0;
                end
            end
            if (pos != wpp_pkg::POS_MAX) pos = pos + CW'(1);
        endfunction

        function void check_peak(logic [31:0] data);
            t_peak pk;
            if (owed_peaks.size() == 0) begin
                $error("unexpected peak transfer: index %0d value %0d",
                       data[15:0], $signed(data[31:16]));
                errors++;
                return;
            end
            pk = owed_peaks.pop_front();
            if (data[15:0] !== pk.index) begin
                $error("peak_index mismatch: expected %0d, actual %0d", pk.index, data[15:0]);
                errors++;
            end
            if (data[31:16] !== pk.value) begin
                $error("peak_value mismatch: expected %0d, actual %0d",
                       pk.value, $signed(data[31:16]));
                errors++;
            end
        endfunction

        function int pending();
            return owed_peaks.size();
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [15:0] sample
    logic [0:0]  s_axis_tuser  = '0;   // [0] record_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [15:0] peak_index, [31:16] peak_value

    peak_scoreboard sb = new();
    bit             no_idle = 1'b0;
    int unsigned    quiet_cycles = 0;

    windowed_peak_picker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Peak side: check each transfer against the oldest owed peak, then roll the stall.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_peak(m_axis_tdata);
        end
        m_axis_tready <= no_idle || ($urandom_range(99) >= 24);
    end

    // Watchdog: give up once no transfer has happened on either stream for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Write one register through a setup and an access cycle; mirror it in the predictor.
    task automatic write_reg(input wpp_pkg::t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        // hold the bus idle before the next access
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic [31:0] win, input logic [31:0] rec,
                                input logic min_mode);
        write_reg(wpp_pkg::REG_WINDOW, win);
        write_reg(wpp_pkg::REG_RECORD, rec);
        write_reg(wpp_pkg::REG_FIND_MIN, {31'd0, min_mode});
    endtask

    // Offer one sample, idling at random first; return once the transfer has happened.
    task automatic send_sample(input logic [15:0] smp, input logic rec_start);
        while (!no_idle && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= rec_start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(smp, rec_start);
    endtask

    // Drop the sample stream and hold until every owed peak has arrived and the block settles.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly full-range samples, with the extremes and a narrow band that forces ties.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(2)) - 16'd1;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [31:0] win;
        logic [31:0] rec;
        logic        first_start;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, no record start yet: the search stays finished.
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        wait_idle();

        // Zero window acts as one; minimum search over a five-sample record.
        write_config(32'd0, 32'd5, 1'b1);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b0);
        wait_idle();

        // Record shorter than two windows: no window opens.
        write_config(32'd3, 32'd5, 1'b0);
        send_sample(16'h1234, 1'b1);
        repeat (3) send_sample(16'h7FFF, 1'b0);
        wait_idle();

        // Oversized record length clips; equal samples check that the first extreme wins.
        write_config(32'd4, 32'h1FFFF, 1'b0);
        send_sample(16'h0005, 1'b1);
        repeat (3) send_sample(16'h0005, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'h5555, 1'b0);
        wait_idle();

        // Empty record with the widest window field.
        write_config(32'h1FFFF, 32'd0, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        wait_idle();

        // Random phases; some carry on without a record start so settings change mid-window.
        for (int p = 0; p < RAND_PHASES; p++) begin
            no_idle = (p == 4 || p == 5);
            case ($urandom_range(9))
                0:       win = 32'd0;
                1:       win = 32'd65536;
                2:       win = $urandom_range(9, 40);
                default: win = $urandom_range(1, 8);
            endcase
            case ($urandom_range(9))
                0:       rec = 32'd0;
                1:       rec = 32'd65536;
                2:       rec = $urandom_range(65537, 131071);
                default: rec = $urandom_range(4, 160);
            endcase
            write_config(win, rec, 1'($urandom_range(1)));
            first_start = ($urandom_range(99) < 80);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_sample(pick_sample(), (i == 0) ? first_start : ($urandom_range(39) == 0));
            end
            wait_idle();
        end
        no_idle = 1'b0;

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
